// ----- rtl/bprm_pkg.sv -----
// package for the block peak and rms level meter
// holds field widths, the frame control struct and the root unit state type
// no dependencies
package bprm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 8;
    localparam int ROOT_BITS = $clog2(LEVEL_W);
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int CFG_W     = 2;

    // per-word control seen by every lane and by the merge stage
    typedef struct packed {
        logic accept;
        logic block_end;
        logic stereo;
    } frame_ctrl_t;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_RUN,
        RMS_DONE
    } rms_state_t;

endpackage

// ----- rtl/bprm_lane.sv -----
// one channel lane: running sum of squares and running scaled peak
// depends on bprm_pkg
module bprm_lane #(
    parameter int LANE  = 0,
    parameter int SUM_W = 38
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bprm_pkg::frame_ctrl_t                  ctrl,
    input  logic signed [bprm_pkg::SAMPLE_W-1:0]   sample,
    output logic        [SUM_W-1:0]                sum_final,
    output logic        [bprm_pkg::LEVEL_W-1:0]    peak_final
);
    import bprm_pkg::*;

    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [LEVEL_W-1:0]        peak_reg, peak_next;
    logic                      active;
    logic signed [31:0]        square;
    logic [SAMPLE_W:0]         mag;
    logic [SAMPLE_W+LEVEL_W:0] mag_scaled;
    logic [LEVEL_W-1:0]        peak_word;

    // channel 0 always counts, channel 1 only while stereo
    assign active = (LANE == 0) || ctrl.stereo;

    // magnitude, square and scaled peak of this word's sample
    assign square     = sample * sample;
    assign mag        = sample[SAMPLE_W-1]
                      ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample}
                      : {1'b0, sample};
    assign mag_scaled = {mag, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, mag};
    assign peak_word  = mag_scaled[SAMPLE_W-1 +: LEVEL_W];

    // totals including the current word
    always_comb begin
        sum_final  = sum_reg;
        peak_final = peak_reg;
        if (active) begin
            sum_final = sum_reg + SUM_W'($unsigned(square));
            if (peak_word > peak_reg) begin
                peak_final = peak_word;
            end
        end
    end

    // update or clear at the end of a block
    always_comb begin
        sum_next  = sum_reg;
        peak_next = peak_reg;
        if (ctrl.accept) begin
            if (ctrl.block_end) begin
                sum_next  = '0;
                peak_next = '0;
            end else begin
                sum_next  = sum_final;
                peak_next = peak_final;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            peak_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

endmodule

// ----- rtl/bprm_rms.sv -----
// bit-serial rms unit: one result bit per cycle, saturates at full scale
// finds the largest k with k*k*BLOCK_FRAMES <= (sum*65025) >> 30; depends on bprm_pkg
module bprm_rms #(
    parameter int BLOCK_FRAMES = 128,
    parameter int SUM_W        = 38
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [SUM_W-1:0]               sum_in,
    input  logic                           take,
    output logic                           done,
    output logic [bprm_pkg::LEVEL_W-1:0]   rms_level
);
    import bprm_pkg::*;

    localparam int PROD_W = SUM_W + 16;
    localparam int CMP_W  = PROD_W - 30;
    localparam int SQ_W   = 2 * LEVEL_W;

    rms_state_t            state_reg, state_next;
    logic [CMP_W-1:0]      prod_reg, prod_next;
    logic [LEVEL_W-1:0]    root_reg, root_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [ROOT_BITS-1:0]  bit_reg, bit_next;

    logic [PROD_W-1:0]     full_prod;
    logic [LEVEL_W-1:0]    trial;
    logic [SQ_W:0]         trial_sq_wide;
    logic [SQ_W-1:0]       trial_sq;
    logic [CMP_W-1:0]      trial_scaled;
    logic                  trial_fits;

    // sum * 65025 as shifts and adds, then drop 30 bits
    assign full_prod = (PROD_W'(sum_in) << 16) - (PROD_W'(sum_in) << 9) + PROD_W'(sum_in);

    // trial square built from the running square: (r + b)^2 = r^2 + 2rb + b^2
    assign trial         = root_reg | (LEVEL_W'(1) << bit_reg);
    assign trial_sq_wide = (SQ_W+1)'(sq_reg)
                         + ((SQ_W+1)'(root_reg) << (bit_reg + 1'b1))
                         + ((SQ_W+1)'(1) << {bit_reg, 1'b0});
    assign trial_sq      = trial_sq_wide[SQ_W-1:0];
    assign trial_scaled  = CMP_W'(trial_sq) * CMP_W'(BLOCK_FRAMES);
    assign trial_fits    = trial_scaled <= prod_reg;

    // sequencer for the eight root bits
    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        root_next  = root_reg;
        sq_next    = sq_reg;
        bit_next   = bit_reg;
        case (state_reg)
            RMS_IDLE: begin
                if (start) begin
                    prod_next  = full_prod[PROD_W-1:30];
                    root_next  = '0;
                    sq_next    = '0;
                    bit_next   = ROOT_BITS'(LEVEL_W - 1);
                    state_next = RMS_RUN;
                end
            end
            RMS_RUN: begin
                if (trial_fits) begin
                    root_next = trial;
                    sq_next   = trial_sq;
                end
                if (bit_reg == '0) begin
                    state_next = RMS_DONE;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            RMS_DONE: begin
                if (take) begin
                    state_next = RMS_IDLE;
                end
            end
            default: begin
                state_next = RMS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RMS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        root_reg <= root_next;
        sq_reg   <= sq_next;
        bit_reg  <= bit_next;
    end

    assign done      = (state_reg == RMS_DONE);
    assign rms_level = root_reg;

endmodule

// ----- rtl/bprm_merge.sv -----
// merge stage: holds block peaks and mode, packs lane results into the output word
// depends on bprm_pkg
module bprm_merge #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  bprm_pkg::frame_ctrl_t                             ctrl,
    input  logic [MAX_CHANNELS-1:0][bprm_pkg::LEVEL_W-1:0]    peak_final,
    input  logic [MAX_CHANNELS-1:0]                           rms_done,
    input  logic [MAX_CHANNELS-1:0][bprm_pkg::LEVEL_W-1:0]    rms_level,
    output logic                                              take,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    output logic [bprm_pkg::M_TDATA_W-1:0]                    m_tdata
);
    import bprm_pkg::*;

    logic [MAX_CHANNELS-1:0][LEVEL_W-1:0] peak_hold_reg;
    logic                                 stereo_reg;
    logic                                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0]                 data_reg;
    logic [M_TDATA_W-1:0]                 packed_word;
    logic                                 use_right;
    logic [LEVEL_W-1:0]                   peak_right, rms_right;

    // capture peaks and mode when the block closes
    always_ff @(posedge aclk) begin
        if (ctrl.accept && ctrl.block_end) begin
            peak_hold_reg <= peak_final;
            stereo_reg    <= ctrl.stereo;
        end
    end

    // right channel reads zero while mono
    assign use_right  = (MAX_CHANNELS >= 2) && stereo_reg;
    assign peak_right = use_right ? peak_hold_reg[MAX_CHANNELS-1] : '0;
    assign rms_right  = use_right ? rms_level[MAX_CHANNELS-1] : '0;
    assign packed_word = {rms_right, peak_right, rms_level[0], peak_hold_reg[0]};

    // output register loads once every lane has its root and the register is empty or being read
    assign take = (&rms_done) && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= packed_word;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- rtl/block_peak_rms_meter.sv -----
// top level of the block peak and rms level meter
// depends on bprm_pkg, bprm_lane, bprm_rms, bprm_merge
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  s_       | s_tvalid / s_tready  | s_tdata: sample_left, sample_right; s_tlast
//  m_       | m_tvalid / m_tready  | m_tdata: peak_left, rms_left, peak_right,
//           |                      |          rms_right
//  cfg_     | cfg_wr_en            | cfg_wr_data: channel_count
//
// one word per cycle inside a block; the word that closes a block starts the
// bit-serial rms units, and once every unit has its root the result is loaded
// into the output register.
// s_tready stays low from the closing word until the result is in the output
// register; a stalled output holds the result and can hold off the next block.
// reset clears sums, peaks, frame count, and sets channel_count to mono.
module block_peak_rms_meter #(
    parameter int BLOCK_FRAMES = 128,
    parameter int MAX_CHANNELS = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bprm_pkg::S_TDATA_W-1:0]    s_tdata,  // sample_left, sample_right
    input  logic                              s_tlast,  // last_frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bprm_pkg::M_TDATA_W-1:0]    m_tdata,  // peak_left, rms_left, peak_right, rms_right
    input  logic                              cfg_wr_en,
    input  logic [bprm_pkg::CFG_W-1:0]        cfg_wr_data  // channel_count
);
    import bprm_pkg::*;

    localparam int FI_W  = $clog2(BLOCK_FRAMES);
    localparam int SUM_W = $clog2(BLOCK_FRAMES) + 31;

    logic [CFG_W-1:0] channel_count_reg;
    logic [FI_W-1:0]  frame_index_reg, frame_index_next;
    logic             busy_reg, busy_next;
    frame_ctrl_t      ctrl;
    logic             take;

    logic [MAX_CHANNELS-1:0][SUM_W-1:0]   sum_final;
    logic [MAX_CHANNELS-1:0][LEVEL_W-1:0] peak_final;
    logic [MAX_CHANNELS-1:0]              rms_done;
    logic [MAX_CHANNELS-1:0][LEVEL_W-1:0] rms_level;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            channel_count_reg <= cfg_wr_data;
        end
    end

    // word control for the lanes and merge stage
    assign s_tready       = !busy_reg;
    assign ctrl.accept    = s_tvalid && s_tready;
    assign ctrl.block_end = (frame_index_reg == FI_W'(BLOCK_FRAMES - 1)) || s_tlast;
    assign ctrl.stereo    = (MAX_CHANNELS >= 2) && channel_count_reg[1];

    // frame counter and busy flag
    always_comb begin
        frame_index_next = frame_index_reg;
        busy_next        = busy_reg;
        if (ctrl.accept) begin
            frame_index_next = ctrl.block_end ? '0 : frame_index_reg + 1'b1;
            if (ctrl.block_end) begin
                busy_next = 1'b1;
            end
        end
        if (take) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_index_reg <= '0;
            busy_reg        <= 1'b0;
        end else begin
            frame_index_reg <= frame_index_next;
            busy_reg        <= busy_next;
        end
    end

    // one lane and one rms unit per channel
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        bprm_lane #(
            .LANE  (i),
            .SUM_W (SUM_W)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sample     ($signed(s_tdata[i*SAMPLE_W +: SAMPLE_W])),
            .sum_final  (sum_final[i]),
            .peak_final (peak_final[i])
        );

        bprm_rms #(
            .BLOCK_FRAMES (BLOCK_FRAMES),
            .SUM_W        (SUM_W)
        ) u_rms (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (ctrl.accept && ctrl.block_end),
            .sum_in    (sum_final[i]),
            .take      (take),
            .done      (rms_done[i]),
            .rms_level (rms_level[i])
        );
    end

    bprm_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .peak_final (peak_final),
        .rms_done   (rms_done),
        .rms_level  (rms_level),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- rtl/bprm_checker.sv -----
// port-level checks for the block peak and rms level meter, bound to the top level
// depends on bprm_pkg and block_peak_rms_meter
module bprm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [bprm_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bprm_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              cfg_wr_en,
    input logic [bprm_pkg::CFG_W-1:0]        cfg_wr_data
);
    import bprm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an accepted word with s_tlast closes its block and drops s_tready
    a_close_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted while a block result is pending");

    // a new result only appears after the input was held off
    a_result_after_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a closed block");

    // rms never exceeds the peak on either channel
    a_rms_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:8] <= m_tdata[7:0]) && (m_tdata[31:24] <= m_tdata[23:16]))
        else $error("rms above peak");

endmodule

bind block_peak_rms_meter bprm_checker u_bprm_checker (.*);

// ----- tb/sv/tb_top.sv -----
// testbench for the block peak and rms level meter
// a scoreboard class predicts peak and rms words per block; plain tasks drive the streams
// depends on bprm_pkg and block_peak_rms_meter
module tb_top;
    import bprm_pkg::*;

    localparam int BLOCK_FRAMES   = 128;
    localparam int MAX_CHANNELS   = 2;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int TARGET_FRAMES  = 1100;
    localparam int DRAIN_CYCLES   = 20000;
    localparam int MAX_PRINTS     = 40;

    // input word, sample_left in the low half
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_right;
        logic signed [SAMPLE_W-1:0] sample_left;
    } frame_word_t;

    // output word, peak_left in the lowest byte
    typedef struct packed {
        logic [LEVEL_W-1:0] rms_right;
        logic [LEVEL_W-1:0] peak_right;
        logic [LEVEL_W-1:0] rms_left;
        logic [LEVEL_W-1:0] peak_left;
    } level_word_t;

    typedef enum int {
        AMP_FULL,
        AMP_SCALED,
        AMP_QUIET,
        AMP_EDGE,
        AMP_MAX
    } amp_class_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_PERIODIC
    } ready_mode_t;

    // level predictor and store of expected output words
    class level_scoreboard;
        level_word_t      expected_levels[$];
        logic [63:0]      square_sum[2];
        logic [7:0]       peak_level[2];
        int               frame_count;
        logic [CFG_W-1:0] channel_count;
        int               errors;
        int               results_checked;

        function new();
            clear_block();
            channel_count   = 1;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void clear_block();
            square_sum[0] = '0;
            square_sum[1] = '0;
            peak_level[0] = '0;
            peak_level[1] = '0;
            frame_count   = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // magnitude of a q15 sample, -32768 gives 32768
        static function logic [16:0] magnitude(logic signed [15:0] x);
            return x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
        endfunction

        static function logic [7:0] scaled_peak(logic [16:0] mag);
            logic [31:0] prod;
            prod = ({15'b0, mag} * 32'd255) >> 15;
            return prod[7:0];
        endfunction

        static function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // short blocks still divide by the full block length
        static function logic [7:0] rms_level(logic [63:0] sum);
            logic [63:0] mean_sq;
            logic [63:0] root;
            mean_sq = (sum * 64'd65025) / (64'(BLOCK_FRAMES) << 30);
            root    = floor_sqrt(mean_sq);
            return (root > 64'd255) ? 8'd255 : root[7:0];
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch: %s", msg);
        endtask

        // accumulate one accepted frame, queue a word when the block closes
        function void note_frame(frame_word_t w, logic last);
            logic        stereo;
            logic [16:0] mag;
            logic [7:0]  p;
            level_word_t lw;
            stereo = (MAX_CHANNELS >= 2) && (channel_count >= 2);

            mag = magnitude(w.sample_left);
            square_sum[0] = square_sum[0] + 64'(mag) * 64'(mag);
            p = scaled_peak(mag);
            if (p > peak_level[0])
                peak_level[0] = p;

            if (stereo) begin
                mag = magnitude(w.sample_right);
                square_sum[1] = square_sum[1] + 64'(mag) * 64'(mag);
                p = scaled_peak(mag);
                if (p > peak_level[1])
                    peak_level[1] = p;
            end

            frame_count++;
            if (frame_count < BLOCK_FRAMES && !last)
                return;

            lw.peak_left  = peak_level[0];
            lw.rms_left   = rms_level(square_sum[0]);
            lw.peak_right = stereo ? peak_level[1] : 8'd0;
            lw.rms_right  = stereo ? rms_level(square_sum[1]) : 8'd0;
            expected_levels.insert(expected_levels.size(), lw);
            clear_block();
        endfunction

        // compare one output word field by field with the oldest expectation
        task check_result(logic [M_TDATA_W-1:0] data);
            level_word_t got;
            level_word_t want;
            got = data;
            results_checked++;
            if (expected_levels.size() == 0) begin
                report($sformatf("word %0d arrived with nothing expected: %h",
                                 results_checked, data));
                return;
            end
            want = expected_levels.pop_front();
            if (got.peak_left !== want.peak_left)
                report($sformatf("word %0d peak_left got %0d want %0d",
                                 results_checked, got.peak_left, want.peak_left));
            if (got.rms_left !== want.rms_left)
                report($sformatf("word %0d rms_left got %0d want %0d",
                                 results_checked, got.rms_left, want.rms_left));
            if (got.peak_right !== want.peak_right)
                report($sformatf("word %0d peak_right got %0d want %0d",
                                 results_checked, got.peak_right, want.peak_right));
            if (got.rms_right !== want.rms_right)
                report($sformatf("word %0d rms_right got %0d want %0d",
                                 results_checked, got.rms_right, want.rms_right));
        endtask

        task report_leftover();
            level_word_t lw;
            while (expected_levels.size() > 0) begin
                lw = expected_levels.pop_front();
                report($sformatf("expected word %h never arrived", lw));
            end
        endtask
    endclass

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // sample_left, sample_right
    logic                   s_tlast     = 1'b0; // last_frame
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // peak_left, rms_left, peak_right, rms_right
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;   // channel_count

    level_scoreboard sb = new();

    int frames_sent = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;

    block_peak_rms_meter #(
        .BLOCK_FRAMES(BLOCK_FRAMES),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // observe both channels, output side first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_frame(frame_word_t'(s_tdata), s_tlast);
        end
    end

    // output side ready pattern, with one long hold-off on request
    initial begin : receiver
        ready_mode_t mode;
        int          epoch_left;
        int          hold_left;
        int          tick;
        mode       = RDY_ALWAYS;
        epoch_left = 0;
        hold_left  = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (epoch_left == 0) begin
                    mode       = ready_mode_t'($urandom_range(RDY_ALWAYS, RDY_PERIODIC));
                    epoch_left = $urandom_range(40, 300);
                end
                epoch_left--;
                case (mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY: m_tready <= ($urandom_range(0, 5) != 0);
                    default:    m_tready <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // random gap after a burst; long bursts leave stretches with no idling
    task pace_sender();
        int gap;
        if (!gaps_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 24);
        gap = $urandom_range(1, 9);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                    input logic last);
        frame_word_t w;
        w.sample_left  = left;
        w.sample_right = right;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
        pace_sender();
    endtask

    // stop offering, wait for every word, then let the rms units settle
    task wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_channels(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.channel_count = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] gen_sample(amp_class_t cls);
        logic [15:0] raw;
        raw = 16'($urandom);
        case (cls)
            AMP_FULL:   return raw;
            AMP_SCALED: return $signed(raw) >>> $urandom_range(1, 14);
            AMP_QUIET:  return $signed(raw) >>> 13;
            AMP_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh8001;
                    default: return raw;
                endcase
            end
            default:    return 16'sh8000;
        endcase
    endfunction

    // one block of random content, mostly short, sometimes full length
    task run_block();
        int         len;
        amp_class_t cls_l;
        amp_class_t cls_r;
        logic       last;
        case ($urandom_range(0, 3))
            0, 1:    len = $urandom_range(1, 16);
            2:       len = $urandom_range(17, BLOCK_FRAMES - 1);
            default: len = BLOCK_FRAMES;
        endcase
        cls_l = amp_class_t'($urandom_range(AMP_FULL, AMP_MAX));
        cls_r = amp_class_t'($urandom_range(AMP_FULL, AMP_MAX));
        for (int i = 1; i <= len; i++) begin
            last = (i == len) && ((len < BLOCK_FRAMES) || ($urandom_range(0, 1) == 1));
            send_frame(gen_sample(cls_l), gen_sample(cls_r), last);
        end
    endtask

    // hold the output side off while frames keep coming, so the input stalls
    task pressure_burst();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 1; i <= 64; i++)
            send_frame(gen_sample(AMP_FULL), gen_sample(AMP_SCALED), (i % 4) == 0);
        gaps_on = 1'b1;
    endtask

    // main sequence
    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mono after reset, right channel ignored
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        send_frame(-16'sd1, 16'sd1, 1'b1);

        // stereo, a single-frame block at full scale, then a two-frame block
        write_channels(2'd2);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sd1, -16'sd1, 1'b0);
        send_frame(16'sh8001, 16'sh7fff, 1'b1);

        // channel count zero acts as mono
        write_channels(2'd0);
        send_frame(16'sd100, -16'sd200, 1'b1);

        // channel count three acts as stereo
        write_channels(2'd3);
        send_frame(16'sh7fff, -16'sd1, 1'b0);
        send_frame(16'sd255, 16'sh8000, 1'b1);

        // stereo block switched to mono before it closes
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sd20000, 16'sd12345, 1'b0);
        write_channels(2'd1);
        send_frame(-16'sd5, 16'sh7fff, 1'b1);

        // mono block switched to stereo before it closes
        send_frame(16'sd7, 16'sd7, 1'b0);
        write_channels(2'd2);
        send_frame(-16'sd9000, -16'sd9000, 1'b1);

        pressure_burst();

        // random phases, each under its own channel setting, some ending mid-block
        while (frames_sent < TARGET_FRAMES) begin
            write_channels(2'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 4)) run_block();
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 20))
                    send_frame(gen_sample(AMP_FULL), gen_sample(AMP_FULL), 1'b0);
        end

        // drain
        s_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_CYCLES && sb.pending() > 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.report_leftover();

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bprm_pkg.sv
rtl/bprm_lane.sv
rtl/bprm_rms.sv
rtl/bprm_merge.sv
rtl/block_peak_rms_meter.sv
rtl/bprm_checker.sv
tb/sv/tb_top.sv
